### design/spicpe_pkg.sv
package spicpe_pkg;

   // Default packet lengths in bytes.
   localparam int RC_BYTES_DEFAULT  = 8;
   localparam int LOG_BYTES_DEFAULT = 12;

   // Configuration port geometry and register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECEIVE_CODE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEND_CODE    = 1'd1;

   // Reset values of the command code registers.
   localparam logic [CSR_DATA_W-1:0] RECEIVE_CODE_RESET = 8'd1;
   localparam logic [CSR_DATA_W-1:0] SEND_CODE_RESET    = 8'd2;

   // Input action codes.
   localparam logic ACTION_SPI_BYTE  = 1'b0;
   localparam logic ACTION_LOG_WRITE = 1'b1;

   // One input transaction.
   typedef struct packed {
      logic        action;
      logic [7:0]  rx_byte;
      logic [1:0]  word_select;
      logic [31:0] word_value;
   } req_type;

   // One result transaction.
   typedef struct packed {
      logic       tx_load;
      logic [7:0] tx_byte;
      logic       rc_write;
      logic [5:0] rc_index;
      logic [7:0] rc_byte;
      logic       rc_last;
   } rsp_type;

endpackage

### design/spicpe_core.sv
module spicpe_core import spicpe_pkg::*; #(
   parameter int RC_BYTES  = RC_BYTES_DEFAULT,
   parameter int LOG_BYTES = LOG_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   step,
   input  req_type                item,
   output rsp_type                result
);

   // Transfer modes.
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_RECV = 2'd1;
   localparam logic [1:0] MODE_SEND = 2'd2;

   localparam logic [6:0] RC_LIMIT  = 7'(RC_BYTES);
   localparam logic [6:0] LOG_LIMIT = 7'(LOG_BYTES);
   localparam logic [6:0] LOG_TOTAL = 7'd12;

   logic [CSR_DATA_W-1:0] receive_code_ff, receive_code_in;
   logic [CSR_DATA_W-1:0] send_code_ff, send_code_in;
   logic [1:0]            mode_ff, mode_in;
   logic [6:0]            counter_ff, counter_in;
   logic [31:0]           log_words_ff [3];
   logic [31:0]           log_words_in [3];
   logic [6:0]            counter_inc;
   logic [3:0]            log_index;
   logic [31:0]           log_word;
   logic [7:0]            log_byte;

   // The user must write command code registers only while the block is idle; the block does not enforce it.
   always_comb begin
      receive_code_in = receive_code_ff;
      send_code_in    = send_code_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_RECEIVE_CODE: receive_code_in = csr_wdata;
            CSR_SEND_CODE:    send_code_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // Log byte lookup: word by the upper index bits, byte lane by the lower two.
   assign counter_inc = counter_ff + 7'd1;

   always_comb begin
      if (mode_ff == MODE_SEND) begin
         log_index = counter_inc[3:0];
      end else begin
         log_index = 4'd0;
      end
      case (log_index[3:2])
         2'd0:    log_word = log_words_ff[0];
         2'd1:    log_word = log_words_ff[1];
         2'd2:    log_word = log_words_ff[2];
         default: log_word = '0;
      endcase
      log_byte = log_word[{log_index[1:0], 3'b000} +: 8];
   end

   // Next state and result for the transaction in the input register.
   always_comb begin
      mode_in         = mode_ff;
      counter_in      = counter_ff;
      log_words_in[0] = log_words_ff[0];
      log_words_in[1] = log_words_ff[1];
      log_words_in[2] = log_words_ff[2];
      result          = '0;
      if (item.action == ACTION_LOG_WRITE) begin
         case (item.word_select)
            2'd0:    log_words_in[0] = item.word_value;
            2'd1:    log_words_in[1] = item.word_value;
            2'd2:    log_words_in[2] = item.word_value;
            default: ;
         endcase
      end else begin
         case (mode_ff)
            MODE_RECV: begin
               result.rc_write = 1'b1;
               result.rc_index = counter_ff[5:0];
               result.rc_byte  = item.rx_byte;
               counter_in      = counter_inc;
               if (counter_inc >= RC_LIMIT) begin
                  result.rc_last = 1'b1;
                  mode_in        = MODE_IDLE;
               end
            end
            MODE_SEND: begin
               counter_in = counter_inc;
               if (counter_inc >= LOG_LIMIT) begin
                  mode_in = MODE_IDLE;
               end else if (counter_inc < LOG_TOTAL) begin
                  result.tx_load = 1'b1;
                  result.tx_byte = log_byte;
               end
            end
            default: begin
               // Idle: the byte is a command; receive wins when codes are equal.
               if (item.rx_byte == receive_code_ff) begin
                  mode_in    = MODE_RECV;
                  counter_in = '0;
               end else if (item.rx_byte == send_code_ff) begin
                  mode_in        = MODE_SEND;
                  counter_in     = '0;
                  result.tx_load = 1'b1;
                  result.tx_byte = log_byte;
               end
            end
         endcase
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         receive_code_ff <= RECEIVE_CODE_RESET;
         send_code_ff    <= SEND_CODE_RESET;
         mode_ff         <= MODE_IDLE;
         counter_ff      <= '0;
         log_words_ff[0] <= '0;
         log_words_ff[1] <= '0;
         log_words_ff[2] <= '0;
      end else begin
         receive_code_ff <= receive_code_in;
         send_code_ff    <= send_code_in;
         if (step) begin
            mode_ff         <= mode_in;
            counter_ff      <= counter_in;
            log_words_ff[0] <= log_words_in[0];
            log_words_ff[1] <= log_words_in[1];
            log_words_ff[2] <= log_words_in[2];
         end
      end
   end

   // A transaction never both loads a transmit byte and stores a packet byte.
   assert property (@(posedge clock) disable iff (reset)
      !(result.tx_load && result.rc_write))
      else $error("transmit load and packet store in one transaction");

   // The last packet byte returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      step && result.rc_last |=> mode_ff == MODE_IDLE)
      else $error("mode not idle after last packet byte");

   // Packet bytes are only stored while receiving.
   assert property (@(posedge clock) disable iff (reset)
      result.rc_write |-> mode_ff == MODE_RECV && counter_ff < RC_LIMIT)
      else $error("packet byte stored outside reception");

endmodule

### design/spi_slave_command_packet_engine.sv
// SPI slave command and packet engine. Each transaction on the req_ channel is
// either a byte received from the SPI master or a host write of one 32-bit log
// word; each produces exactly one transaction on the rsp_ channel. A new
// transaction is accepted every cycle while rsp_stall is low. Its result waits
// in the input register until the output register is free, then the mode,
// counter and log words are updated as the result moves into the output
// register. The only stall comes from rsp_stall, which holds the output
// register and, once the input register is also full, req_stall. Command codes
// are set through the csr_ port (index 0 receive command, index 1 send command);
// the user must write them only while the block is idle, which the block itself
// does not enforce. There is no memory and no clearing time after reset.
module spi_slave_command_packet_engine import spicpe_pkg::*; #(
   parameter int RC_BYTES  = RC_BYTES_DEFAULT,
   parameter int LOG_BYTES = LOG_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type result;
   logic    out_ready;
   logic    step;

   // Pipeline flow control: the output register frees when it is empty or taken.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !out_ready);
   assign out_valid_in = step || (out_valid_ff && rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   spicpe_core #(
      .RC_BYTES  (RC_BYTES),
      .LOG_BYTES (LOG_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .item      (in_data_ff),
      .result    (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A held input transaction is not dropped while the output is blocked.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_ready |=> in_valid_ff && $stable(in_data_ff))
      else $error("input transaction lost while output stalled");

   // A processed transaction always shows up at the output.
   assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("processed transaction missing at output");

   // The input side is only held back when both registers are full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("input stalled with free pipeline space");

endmodule

### tb/tb_spi_slave_command_packet_engine.sv
module tb_spi_slave_command_packet_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import spicpe_pkg::*;

   localparam int RUN_LIMIT    = 300000;
   localparam int RANDOM_ITEMS = 1100;
   localparam int LOG_SLOTS    = 12;

   // Log word selectors as carried in word_select.
   localparam logic [1:0] WORD_ROLL   = 2'd0;
   localparam logic [1:0] WORD_PITCH  = 2'd1;
   localparam logic [1:0] WORD_YAW    = 2'd2;
   localparam logic [1:0] WORD_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      ENG_IDLE  = 2'd0,
      ENG_RECV  = 2'd1,
      ENG_SEND  = 2'd2,
      ENG_SPARE = 2'd3
   } engine_mode_t;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;

   // Shadow copy of the engine state and command codes.
   engine_mode_t model_mode;
   logic [6:0]   model_count;
   logic [31:0]  model_log [3];
   logic [7:0]   model_rx_code;
   logic [7:0]   model_tx_code;

   rsp_type expected_rsp [$];
   int      error_count    = 0;
   int      cycle_count    = 0;
   int      txn_count      = 0;
   int      req_gap_odds   = 0;
   int      rsp_stall_odds = 0;
   int      stall_left     = 0;

   spi_slave_command_packet_engine dut (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result-side back-pressure in bursts of random length.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1) begin
         stall_left <= $urandom_range(0, 9);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [7:0] log_byte_at(logic [6:0] idx);
      if (idx >= LOG_SLOTS) return 8'h00;
      return model_log[idx / 4][(idx % 4) * 8 +: 8];
   endfunction

   // Advance the shadow engine by one transaction and return the result it owes.
   function automatic rsp_type predict_engine(req_type t);
      rsp_type r;
      r = '0;
      if (t.action == ACTION_LOG_WRITE) begin
         if (t.word_select != WORD_UNUSED) model_log[t.word_select] = t.word_value;
      end else if (model_mode == ENG_RECV) begin
         r.rc_write  = 1'b1;
         r.rc_index  = model_count[5:0];
         r.rc_byte   = t.rx_byte;
         model_count = model_count + 7'd1;
         if (model_count >= RC_BYTES_DEFAULT) begin
            r.rc_last  = 1'b1;
            model_mode = ENG_IDLE;
         end
      end else if (model_mode == ENG_SEND) begin
         model_count = model_count + 7'd1;
         if (model_count >= LOG_BYTES_DEFAULT) begin
            model_mode = ENG_IDLE;
         end else if (model_count < LOG_SLOTS) begin
            r.tx_load = 1'b1;
            r.tx_byte = log_byte_at(model_count);
         end
      end else begin
         // Idle, and the unused mode encoding, treat the byte as a command.
         if (t.rx_byte == model_rx_code) begin
            model_mode  = ENG_RECV;
            model_count = '0;
         end else if (t.rx_byte == model_tx_code) begin
            model_mode  = ENG_SEND;
            model_count = '0;
            r.tx_load   = 1'b1;
            r.tx_byte   = log_byte_at(7'd0);
         end
      end
      return r;
   endfunction

   function automatic string show_rsp(rsp_type r);
      return $sformatf("tx_load=%0b tx_byte=%02h rc_write=%0b rc_index=%0d rc_byte=%02h rc_last=%0b",
                       r.tx_load, r.tx_byte, r.rc_write, r.rc_index, r.rc_byte, r.rc_last);
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endfunction

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            flag_error($sformatf("result with nothing pending: %s", show_rsp(rsp_data)));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data !== want)
               flag_error($sformatf("expected %s, got %s", show_rsp(want), show_rsp(rsp_data)));
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // The unused fields carry noise so that the block is seen to ignore them.
   function automatic req_type spi_txn(logic [7:0] b);
      req_type t;
      t.action      = ACTION_SPI_BYTE;
      t.rx_byte     = b;
      t.word_select = 2'($urandom_range(0, 3));
      t.word_value  = $urandom;
      return t;
   endfunction

   function automatic req_type log_txn(logic [1:0] sel, logic [31:0] value);
      req_type t;
      t.action      = ACTION_LOG_WRITE;
      t.rx_byte     = 8'($urandom_range(0, 255));
      t.word_select = sel;
      t.word_value  = value;
      return t;
   endfunction

   // Present one transaction, wait for it to be taken, then record its prediction.
   task automatic send_txn(req_type t);
      int  gap;
      bit  ignored;
      @(negedge clock);
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      if (t.action == ACTION_LOG_WRITE)
         ignored = (t.word_select == WORD_UNUSED);
      else
         ignored = (model_mode != ENG_RECV && model_mode != ENG_SEND &&
                    t.rx_byte != model_rx_code && t.rx_byte != model_tx_code);
      if (!ignored) txn_count++;
      expected_rsp.push_back(predict_engine(t));
   endtask

   // Stop sending and let every outstanding result come back.
   task automatic settle_engine();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_code(logic [CSR_INDEX_W-1:0] idx, logic [7:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_RECEIVE_CODE) model_rx_code = value;
      else model_tx_code = value;
   endtask

   // Feed filler bytes until any packet in progress has ended.
   task automatic finish_packet();
      while (model_mode == ENG_RECV || model_mode == ENG_SEND)
         send_txn(spi_txn(rand_byte()));
   endtask

   // One random sequence: a full RC packet, a full log readout, or noise.
   task automatic run_sequence();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 75) finish_packet();
      if (pick < 40) begin
         send_txn(spi_txn(model_rx_code));
         for (int i = 0; i < RC_BYTES_DEFAULT; i++) begin
            if ($urandom_range(0, 7) == 0)
               send_txn(log_txn(2'($urandom_range(0, 2)), rand_word()));
            send_txn(spi_txn(rand_byte()));
         end
      end else if (pick < 75) begin
         send_txn(spi_txn(model_tx_code));
         for (int i = 0; i < LOG_BYTES_DEFAULT; i++) begin
            if ($urandom_range(0, 7) == 0)
               send_txn(log_txn(2'($urandom_range(0, 2)), rand_word()));
            send_txn(spi_txn(rand_byte()));
         end
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            if ($urandom_range(0, 1) == 0)
               send_txn(spi_txn(rand_byte()));
            else
               send_txn(log_txn(2'($urandom_range(0, 3)), rand_word()));
         end
      end
   endtask

   // Host writes to each log word, the unused selector, and unknown commands.
   task automatic test_host_log_writes();
      send_txn(log_txn(WORD_ROLL, 32'hFFFF_FFFF));
      send_txn(log_txn(WORD_PITCH, 32'h7856_3412));
      send_txn(log_txn(WORD_YAW, 32'h0000_0080));
      send_txn(log_txn(WORD_UNUSED, 32'hDEAD_BEEF));
      send_txn(spi_txn(8'h00));
      send_txn(spi_txn(8'hFF));
      settle_engine();
   endtask

   // Full log readout with the yaw word rewritten part way through.
   task automatic test_log_transmit();
      send_txn(spi_txn(model_tx_code));
      repeat (5) send_txn(spi_txn(8'h00));
      send_txn(log_txn(WORD_YAW, 32'hA5C3_0F96));
      repeat (7) send_txn(spi_txn(8'hFF));
      settle_engine();
   endtask

   // Full RC packet with extreme data bytes.
   task automatic test_rc_receive();
      send_txn(spi_txn(model_rx_code));
      send_txn(spi_txn(8'h00));
      send_txn(spi_txn(8'hFF));
      repeat (RC_BYTES_DEFAULT - 2) send_txn(spi_txn(rand_byte()));
      settle_engine();
   endtask

   // Random traffic under several command code settings, the extremes and equal
   // codes among them; the second half of the last phase runs without idling.
   task automatic test_random_traffic();
      logic [7:0] rx_codes [5];
      logic [7:0] tx_codes [5];
      int         per_phase;
      int         mark;
      int         stretch;
      rx_codes  = '{8'd0, 8'd255, 8'h5A, 8'd0, RECEIVE_CODE_RESET};
      tx_codes  = '{8'd255, 8'd0, 8'h5A, 8'd0, SEND_CODE_RESET};
      rx_codes[3] = 8'($urandom_range(0, 255));
      tx_codes[3] = 8'($urandom_range(0, 255));
      per_phase = RANDOM_ITEMS / 5;
      for (int p = 0; p < 5; p++) begin
         finish_packet();
         settle_engine();
         write_code(CSR_RECEIVE_CODE, rx_codes[p]);
         write_code(CSR_SEND_CODE, tx_codes[p]);
         mark    = txn_count;
         stretch = txn_count;
         while (txn_count - mark < per_phase) begin
            if (p == 4 && txn_count - mark >= per_phase / 2) begin
               req_gap_odds   = 0;
               rsp_stall_odds = 0;
            end else if (txn_count - stretch >= 60) begin
               stretch = txn_count;
               case ($urandom_range(0, 3))
                  0: begin req_gap_odds = 0; rsp_stall_odds = 0; end
                  1: begin req_gap_odds = 3; rsp_stall_odds = 3; end
                  2: begin req_gap_odds = 6; rsp_stall_odds = 0; end
                  default: begin req_gap_odds = 0; rsp_stall_odds = 4; end
               endcase
            end
            run_sequence();
         end
      end
   endtask

   initial begin
      model_mode     = ENG_IDLE;
      model_count    = '0;
      model_log[0]   = '0;
      model_log[1]   = '0;
      model_log[2]   = '0;
      model_rx_code  = RECEIVE_CODE_RESET;
      model_tx_code  = SEND_CODE_RESET;
      req_gap_odds   = 4;
      rsp_stall_odds = 4;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_host_log_writes();
      test_log_transmit();
      test_rc_receive();
      test_random_traffic();
      settle_engine();

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### spi_slave_command_packet_engine.f
design/spicpe_pkg.sv
design/spicpe_core.sv
design/spi_slave_command_packet_engine.sv
tb/tb_spi_slave_command_packet_engine.sv
